/* rtl/core/spq_pkg.sv */
`timescale 1ns / 1ps

package spq_pkg;

    localparam int SPQ_CAPACITY     = 16;
    localparam int SPQ_KEY_BITS     = 16;
    localparam int SPQ_PAYLOAD_BITS = 16;
    localparam int SPQ_COUNT_BITS   = 5;

    typedef enum logic
    {
        MODE_INSERT = 1'b0,
        MODE_POP    = 1'b1
    } mode_t;

    typedef struct packed
    {
        mode_t                         mode;
        logic [SPQ_KEY_BITS-1:0]       key;
        logic [SPQ_PAYLOAD_BITS-1:0]   payload;
    } cmd_t;

    typedef struct packed
    {
        logic [SPQ_KEY_BITS-1:0]       out_key;
        logic [SPQ_PAYLOAD_BITS-1:0]   out_payload;
        logic                          was_empty;
        logic                          was_full;
        logic [SPQ_COUNT_BITS-1:0]     entry_count;
    } res_t;

    typedef struct packed
    {
        logic [SPQ_KEY_BITS-1:0]       key;
        logic [SPQ_PAYLOAD_BITS-1:0]   payload;
    } entry_t;

    // per-cell control from the queue controller
    typedef struct packed
    {
        logic ins;        // insert transaction that will be stored
        logic pop;        // pop transaction on a non-empty queue
        logic stay;       // this cell keeps its entry on insert
        logic prev_stay;  // left neighbor keeps its entry (new entry lands here)
    } cell_ctl_t;

    // local key compare against the broadcast insert key
    typedef struct packed
    {
        logic lt;
        logic le;
    } cell_cmp_t;

endpackage

/* rtl/core/spq_cell.sv */
`timescale 1ns / 1ps

module spq_cell
(
    input  logic                clk,
    input  spq_pkg::cell_ctl_t  ctl,
    input  spq_pkg::entry_t     new_entry,
    input  spq_pkg::entry_t     prev_entry,
    input  spq_pkg::entry_t     next_entry,
    output spq_pkg::entry_t     entry,
    output spq_pkg::cell_cmp_t  cmp
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    always_comb
    begin
        cmp.lt = entry_reg.key <  new_entry.key;
        cmp.le = entry_reg.key <= new_entry.key;
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins && !ctl.stay)
        begin
            entry_next = ctl.prev_stay ? new_entry : prev_entry;
        end
        else if (ctl.pop)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

/* rtl/core/sorted_priority_queue_top.sv */
`timescale 1ns / 1ps
// a result is registered and appears in the cycle after its transaction is accepted
// throughput: one insert or pop per cycle while cmd_stall is low; every cell compares and shifts locally
// the only stall comes from a held result register while res_stall is high
// reset: fill count and result valid clear asynchronously; cell contents stay
// undefined and are only read below the fill count

module sorted_priority_queue_top
#(
    parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  spq_pkg::cmd_t  cmd,
    output logic           res_valid,
    input  logic           res_stall,
    output spq_pkg::res_t  res
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   res_valid_reg;
    logic                   res_valid_next;
    spq_pkg::res_t          res_reg;
    spq_pkg::res_t          res_next;

    logic                   accept;
    logic                   is_full;
    logic                   is_empty;
    logic                   do_ins;
    logic                   do_pop;

    spq_pkg::entry_t        new_entry;
    spq_pkg::entry_t        cell_entry [CAPACITY];
    spq_pkg::cell_cmp_t     cell_cmp   [CAPACITY];
    logic [CAPACITY-1:0]    stay;

    assign cmd_stall = res_valid_reg && res_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign is_full   = count_reg == CW'(CAPACITY);
    assign is_empty  = count_reg == '0;
    assign do_ins    = accept && (cmd.mode == spq_pkg::MODE_INSERT) && !is_full;
    assign do_pop    = accept && (cmd.mode == spq_pkg::MODE_POP) && !is_empty;

    always_comb
    begin
        new_entry.key     = cmd.key;
        new_entry.payload = cmd.payload;
    end

    // front cell stays only on a strictly smaller key; a key equal to the
    // front goes ahead of it, otherwise equal keys keep arrival order
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (i == 0)
            begin
                stay[i] = (CW'(i) < count_reg) && cell_cmp[i].lt;
            end
            else
            begin
                stay[i] = (CW'(i) < count_reg) && cell_cmp[i].le && stay[0];
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        spq_pkg::cell_ctl_t ctl;
        spq_pkg::entry_t    prev_entry;
        spq_pkg::entry_t    next_entry;

        always_comb
        begin
            ctl.ins  = do_ins;
            ctl.pop  = do_pop;
            ctl.stay = stay[g];
            if (g == 0)
            begin
                ctl.prev_stay = 1'b1;
                prev_entry    = '0;
            end
            else
            begin
                ctl.prev_stay = stay[(g > 0) ? g - 1 : 0];
                prev_entry    = cell_entry[(g > 0) ? g - 1 : 0];
            end
            if (g == CAPACITY - 1)
            begin
                next_entry = '0;
            end
            else
            begin
                next_entry = cell_entry[(g < CAPACITY - 1) ? g + 1 : g];
            end
        end

        spq_cell u_cell
        (
            .clk        (clk),
            .ctl        (ctl),
            .new_entry  (new_entry),
            .prev_entry (prev_entry),
            .next_entry (next_entry),
            .entry      (cell_entry[g]),
            .cmp        (cell_cmp[g])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        if (accept)
        begin
            res_valid_next       = 1'b1;
            res_next.out_key     = do_pop ? cell_entry[0].key : '0;
            res_next.out_payload = do_pop ? cell_entry[0].payload : '0;
            res_next.was_empty   = (cmd.mode == spq_pkg::MODE_POP) && is_empty;
            res_next.was_full    = (cmd.mode == spq_pkg::MODE_INSERT) && is_full;
            res_next.entry_count = spq_pkg::SPQ_COUNT_BITS'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_ins |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the queue");

    a_pop_front: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop |=> res_valid && !res.was_empty
                   && res.out_key == $past(cell_entry[0].key))
        else $error("pop did not return the front entry");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.was_empty && res.was_full))
        else $error("empty and full flags together");
`endif

endmodule
